// ===== hdl/fcgi_pkg.sv =====
// Shared types, codes and constants for the FastCGI record parser.
package fcgi_pkg;

   localparam int PAIR_LEN_BITS_DEF = 31;
   localparam int PAIR_LEN_MAX      = 31;

   localparam logic [7:0] FCGI_VERSION = 8'd1;
   localparam logic [7:0] TYPE_LIMIT   = 8'd11;
   localparam logic [3:0] TYPE_BEGIN   = 4'd1;
   localparam logic [3:0] TYPE_PARAMS  = 4'd4;
   localparam logic [3:0] TYPE_STDIN   = 4'd5;
   localparam logic [15:0] ROLE_RESPONDER = 16'd1;

   typedef enum logic [1:0] {
      KIND_FRAME = 2'd0,
      KIND_NAME  = 2'd1,
      KIND_VALUE = 2'd2,
      KIND_STDIN = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_BAD_VERSION = 3'd1,
      ST_BAD_TYPE    = 3'd2,
      ST_UNSUP_TYPE  = 3'd3,
      ST_UNSUP_ROLE  = 3'd4
   } status_type;

   typedef enum logic [27:0] {
      PH_VER   = 28'b1 << 0,
      PH_TYPE  = 28'b1 << 1,
      PH_ID1   = 28'b1 << 2,
      PH_ID2   = 28'b1 << 3,
      PH_CL1   = 28'b1 << 4,
      PH_CL2   = 28'b1 << 5,
      PH_PL    = 28'b1 << 6,
      PH_RSV   = 28'b1 << 7,
      PH_ROLE1 = 28'b1 << 8,
      PH_ROLE2 = 28'b1 << 9,
      PH_FLAGS = 28'b1 << 10,
      PH_BR1   = 28'b1 << 11,
      PH_BR2   = 28'b1 << 12,
      PH_BR3   = 28'b1 << 13,
      PH_BR4   = 28'b1 << 14,
      PH_BR5   = 28'b1 << 15,
      PH_KL1   = 28'b1 << 16,
      PH_KL2   = 28'b1 << 17,
      PH_KL3   = 28'b1 << 18,
      PH_KL4   = 28'b1 << 19,
      PH_KEY   = 28'b1 << 20,
      PH_VL1   = 28'b1 << 21,
      PH_VL2   = 28'b1 << 22,
      PH_VL3   = 28'b1 << 23,
      PH_VL4   = 28'b1 << 24,
      PH_VAL   = 28'b1 << 25,
      PH_STDIN = 28'b1 << 26,
      PH_PAD   = 28'b1 << 27
   } phase_type;

   typedef struct packed {
      phase_type   phase;
      logic [3:0]  record_type;
      logic [15:0] current_id;
      logic [15:0] last_ended_id;
      logic [15:0] content_left;
      logic [7:0]  padding_left;
      logic [7:0]  role_high;
      logic [7:0]  flag_bits;
   } parse_state_type;

   typedef struct packed {
      kind_type    byte_kind;
      logic [7:0]  out_byte;
      logic        key_done;
      logic        param_done;
      logic        begin_done;
      logic        input_end;
      logic [15:0] rec_id;
      logic        keep_conn;
      status_type  status;
   } result_type;

endpackage

// ===== hdl/fastcgi_record_parser.sv =====
// Path: input register -> decode -> result register (2-stage path).
// Throughput: one byte per cycle sustained while the output does not stall.
// Parse state advances when a byte moves from the input register to the result register.
// Back-pressure stalls only when both the input and result registers hold a beat.
// Reset (synchronous, active high): expect-version phase, counters and ids zero,
// repeat-empty-stdin drop enabled.
module fastcgi_record_parser #(
   parameter int PAIR_LEN_BITS = fcgi_pkg::PAIR_LEN_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_byte_kind,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_key_done,
   output logic        rsp_param_done,
   output logic        rsp_begin_done,
   output logic        rsp_input_end,
   output logic [15:0] rsp_rec_id,
   output logic        rsp_keep_conn,
   output logic [2:0]  rsp_status,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   logic                      drop_repeat_ff;
   logic                      in_valid_ff;
   logic                      in_valid_in;
   logic [7:0]                in_byte_ff;
   logic                      advance;
   logic                      room;
   fcgi_pkg::parse_state_type state_ff;
   fcgi_pkg::parse_state_type state_in;
   logic [PAIR_LEN_BITS-1:0]  name_left_ff;
   logic [PAIR_LEN_BITS-1:0]  name_left_in;
   logic [PAIR_LEN_BITS-1:0]  value_left_ff;
   logic [PAIR_LEN_BITS-1:0]  value_left_in;
   fcgi_pkg::result_type      result;
   fcgi_pkg::result_type      rsp_data;

   assign advance     = in_valid_ff && room;
   assign req_ready   = !in_valid_ff || advance;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         drop_repeat_ff <= 1'b1;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_wr_en) begin
            drop_repeat_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= '{phase: fcgi_pkg::PH_VER, default: '0};
         name_left_ff  <= '0;
         value_left_ff <= '0;
      end else if (advance) begin
         state_ff      <= state_in;
         name_left_ff  <= name_left_in;
         value_left_ff <= value_left_in;
      end
   end

   fcgi_step #(
      .PAIR_LEN_BITS(PAIR_LEN_BITS)
   ) u_step (
      .drop_repeat  (drop_repeat_ff),
      .in_byte      (in_byte_ff),
      .state_q      (state_ff),
      .name_left_q  (name_left_ff),
      .value_left_q (value_left_ff),
      .state_d      (state_in),
      .name_left_d  (name_left_in),
      .value_left_d (value_left_in),
      .result       (result)
   );

   fcgi_rsp_reg u_rsp (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .result_in  (result),
      .rsp_ready  (rsp_ready),
      .room       (room),
      .rsp_valid  (rsp_valid),
      .result_out (rsp_data)
   );

   assign rsp_byte_kind  = rsp_data.byte_kind;
   assign rsp_out_byte   = rsp_data.out_byte;
   assign rsp_key_done   = rsp_data.key_done;
   assign rsp_param_done = rsp_data.param_done;
   assign rsp_begin_done = rsp_data.begin_done;
   assign rsp_input_end  = rsp_data.input_end;
   assign rsp_rec_id     = rsp_data.rec_id;
   assign rsp_keep_conn  = rsp_data.keep_conn;
   assign rsp_status     = rsp_data.status;

`ifndef SYNTHESIS
   // an error beat never carries payload
   a_err_is_framing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != fcgi_pkg::ST_OK |-> rsp_byte_kind == fcgi_pkg::KIND_FRAME)
      else $error("error beat tagged as payload");

   // key_done only on a name byte
   a_key_done_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_key_done |-> rsp_byte_kind == fcgi_pkg::KIND_NAME)
      else $error("key_done on a non-name byte");

   // a rejected byte leaves the parse state untouched
   a_err_holds_state: assert property (@(posedge clock) disable iff (reset)
      advance && result.status != fcgi_pkg::ST_OK |=>
         state_ff == $past(state_ff) && name_left_ff == $past(name_left_ff)
         && value_left_ff == $past(value_left_ff))
      else $error("parse state changed on an error byte");

   // both stages full and output stalled: no new beat may enter
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input accepted while pipeline is full");

   // begin_done beats are framing beats with no param events
   a_begin_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_begin_done |-> !rsp_param_done && !rsp_input_end
         && rsp_byte_kind == fcgi_pkg::KIND_FRAME)
      else $error("begin event mixed with other events");
`endif

endmodule

// ===== hdl/fcgi_step.sv =====
// Per-byte decode: next parse state and the result for one stream byte.
module fcgi_step #(
   parameter int PAIR_LEN_BITS = fcgi_pkg::PAIR_LEN_BITS_DEF
) (
   input  logic                         drop_repeat,
   input  logic [7:0]                   in_byte,
   input  fcgi_pkg::parse_state_type    state_q,
   input  logic [PAIR_LEN_BITS-1:0]     name_left_q,
   input  logic [PAIR_LEN_BITS-1:0]     value_left_q,
   output fcgi_pkg::parse_state_type    state_d,
   output logic [PAIR_LEN_BITS-1:0]     name_left_d,
   output logic [PAIR_LEN_BITS-1:0]     value_left_d,
   output fcgi_pkg::result_type         result
);

   localparam int LW = PAIR_LEN_BITS;
   localparam int MW = fcgi_pkg::PAIR_LEN_MAX;

   logic [MW-1:0]  name_ext;
   logic [MW-1:0]  value_ext;
   logic [MW-1:0]  len_hi;
   logic [MW-1:0]  len_b2;
   logic [MW-1:0]  len_b1;
   logic [MW-1:0]  len_b0;
   logic [LW-1:0]  name_dec;
   logic [LW-1:0]  value_dec;
   logic [15:0]    content_dec;
   logic [7:0]     padding_dec;
   logic           params;
   fcgi_pkg::phase_type end_phase;

   assign name_ext    = MW'(name_left_q);
   assign value_ext   = MW'(value_left_q);
   assign len_hi      = {in_byte[6:0], 24'h0};
   assign len_b2      = {7'h0, in_byte, 16'h0};
   assign len_b1      = {15'h0, in_byte, 8'h0};
   assign len_b0      = {23'h0, in_byte};
   assign name_dec    = name_left_q - LW'(1);
   assign value_dec   = value_left_q - LW'(1);
   assign content_dec = state_q.content_left - 16'd1;
   assign padding_dec = state_q.padding_left - 8'd1;
   assign end_phase   = (state_q.padding_left == 8'd0) ? fcgi_pkg::PH_VER : fcgi_pkg::PH_PAD;

   always_comb begin
      logic [MW-1:0] sum;
      sum          = '0;
      state_d      = state_q;
      name_left_d  = name_left_q;
      value_left_d = value_left_q;
      params       = 1'b0;
      result       = '0;
      result.byte_kind = fcgi_pkg::KIND_FRAME;
      result.status    = fcgi_pkg::ST_OK;

      case (state_q.phase)
         fcgi_pkg::PH_TYPE: begin
            if (in_byte >= fcgi_pkg::TYPE_LIMIT) begin
               result.status = fcgi_pkg::ST_BAD_TYPE;
            end else begin
               state_d.record_type = in_byte[3:0];
               state_d.phase       = fcgi_pkg::PH_ID1;
            end
         end
         fcgi_pkg::PH_ID1: begin
            state_d.current_id = {in_byte, 8'h0};
            state_d.phase      = fcgi_pkg::PH_ID2;
         end
         fcgi_pkg::PH_ID2: begin
            state_d.current_id = state_q.current_id | {8'h0, in_byte};
            state_d.phase      = fcgi_pkg::PH_CL1;
         end
         fcgi_pkg::PH_CL1: begin
            state_d.content_left = {in_byte, 8'h0};
            state_d.phase        = fcgi_pkg::PH_CL2;
         end
         fcgi_pkg::PH_CL2: begin
            state_d.content_left = state_q.content_left | {8'h0, in_byte};
            state_d.phase        = fcgi_pkg::PH_PL;
         end
         fcgi_pkg::PH_PL: begin
            state_d.padding_left = in_byte;
            state_d.phase        = fcgi_pkg::PH_RSV;
         end
         fcgi_pkg::PH_RSV: begin
            if (state_q.content_left != 16'd0) begin
               if (state_q.record_type == fcgi_pkg::TYPE_BEGIN) begin
                  state_d.phase = fcgi_pkg::PH_ROLE1;
               end else if (state_q.record_type == fcgi_pkg::TYPE_PARAMS) begin
                  state_d.phase = fcgi_pkg::PH_KL1;
               end else if (state_q.record_type == fcgi_pkg::TYPE_STDIN) begin
                  state_d.phase = fcgi_pkg::PH_STDIN;
               end else begin
                  result.status = fcgi_pkg::ST_UNSUP_TYPE;
               end
            end else if (state_q.record_type == fcgi_pkg::TYPE_PARAMS) begin
               state_d.phase = end_phase;
            end else if (state_q.record_type == fcgi_pkg::TYPE_STDIN) begin
               // empty stdin closes the request unless drop_repeat is set and it repeats the last id
               result.input_end      = !(drop_repeat &&
                                         state_q.last_ended_id == state_q.current_id);
               state_d.last_ended_id = state_q.current_id;
               state_d.phase         = end_phase;
            end else begin
               result.status = fcgi_pkg::ST_UNSUP_TYPE;
            end
         end
         fcgi_pkg::PH_ROLE1: begin
            state_d.content_left = content_dec;
            state_d.role_high    = in_byte;
            state_d.phase        = fcgi_pkg::PH_ROLE2;
         end
         fcgi_pkg::PH_ROLE2: begin
            if ({state_q.role_high, in_byte} != fcgi_pkg::ROLE_RESPONDER) begin
               result.status = fcgi_pkg::ST_UNSUP_ROLE;
            end else begin
               state_d.content_left = content_dec;
               state_d.phase        = fcgi_pkg::PH_FLAGS;
            end
         end
         fcgi_pkg::PH_FLAGS: begin
            state_d.content_left = content_dec;
            state_d.flag_bits    = in_byte;
            state_d.phase        = fcgi_pkg::PH_BR1;
         end
         fcgi_pkg::PH_BR1: begin
            state_d.content_left = content_dec;
            state_d.phase        = fcgi_pkg::PH_BR2;
         end
         fcgi_pkg::PH_BR2: begin
            state_d.content_left = content_dec;
            state_d.phase        = fcgi_pkg::PH_BR3;
         end
         fcgi_pkg::PH_BR3: begin
            state_d.content_left = content_dec;
            state_d.phase        = fcgi_pkg::PH_BR4;
         end
         fcgi_pkg::PH_BR4: begin
            state_d.content_left = content_dec;
            state_d.phase        = fcgi_pkg::PH_BR5;
         end
         fcgi_pkg::PH_BR5: begin
            state_d.content_left = content_dec;
            result.begin_done    = 1'b1;
            result.keep_conn     = state_q.flag_bits[0];
            state_d.phase        = end_phase;
         end
         fcgi_pkg::PH_KL1: begin
            params = 1'b1;
            if (in_byte[7]) begin
               name_left_d   = len_hi[LW-1:0];
               state_d.phase = fcgi_pkg::PH_KL2;
            end else begin
               name_left_d   = len_b0[LW-1:0];
               state_d.phase = fcgi_pkg::PH_VL1;
            end
         end
         fcgi_pkg::PH_KL2: begin
            params        = 1'b1;
            sum           = name_ext + len_b2;
            name_left_d   = sum[LW-1:0];
            state_d.phase = fcgi_pkg::PH_KL3;
         end
         fcgi_pkg::PH_KL3: begin
            params        = 1'b1;
            sum           = name_ext + len_b1;
            name_left_d   = sum[LW-1:0];
            state_d.phase = fcgi_pkg::PH_KL4;
         end
         fcgi_pkg::PH_KL4: begin
            params        = 1'b1;
            sum           = name_ext + len_b0;
            name_left_d   = sum[LW-1:0];
            state_d.phase = fcgi_pkg::PH_VL1;
         end
         fcgi_pkg::PH_VL1, fcgi_pkg::PH_VL4: begin
            params = 1'b1;
            if (state_q.phase == fcgi_pkg::PH_VL1 && in_byte[7]) begin
               value_left_d  = len_hi[LW-1:0];
               state_d.phase = fcgi_pkg::PH_VL2;
            end else begin
               sum          = (state_q.phase == fcgi_pkg::PH_VL1) ? len_b0 : value_ext + len_b0;
               value_left_d = sum[LW-1:0];
               // lengths complete: pick the first non-empty part of the pair
               if (name_left_q != '0) begin
                  state_d.phase = fcgi_pkg::PH_KEY;
               end else if (sum[LW-1:0] != '0) begin
                  state_d.phase = fcgi_pkg::PH_VAL;
               end else begin
                  result.param_done = 1'b1;
                  state_d.phase     = fcgi_pkg::PH_KL1;
               end
            end
         end
         fcgi_pkg::PH_VL2: begin
            params        = 1'b1;
            sum           = value_ext + len_b2;
            value_left_d  = sum[LW-1:0];
            state_d.phase = fcgi_pkg::PH_VL3;
         end
         fcgi_pkg::PH_VL3: begin
            params        = 1'b1;
            sum           = value_ext + len_b1;
            value_left_d  = sum[LW-1:0];
            state_d.phase = fcgi_pkg::PH_VL4;
         end
         fcgi_pkg::PH_KEY: begin
            params           = 1'b1;
            result.byte_kind = fcgi_pkg::KIND_NAME;
            result.out_byte  = in_byte;
            name_left_d      = name_dec;
            if (name_dec == '0) begin
               result.key_done = 1'b1;
               if (value_left_q != '0) begin
                  state_d.phase = fcgi_pkg::PH_VAL;
               end else begin
                  result.param_done = 1'b1;
                  state_d.phase     = fcgi_pkg::PH_KL1;
               end
            end
         end
         fcgi_pkg::PH_VAL: begin
            params           = 1'b1;
            result.byte_kind = fcgi_pkg::KIND_VALUE;
            result.out_byte  = in_byte;
            value_left_d     = value_dec;
            if (value_dec == '0) begin
               result.param_done = 1'b1;
               state_d.phase     = fcgi_pkg::PH_KL1;
            end
         end
         fcgi_pkg::PH_STDIN: begin
            result.byte_kind     = fcgi_pkg::KIND_STDIN;
            result.out_byte      = in_byte;
            state_d.content_left = content_dec;
            if (content_dec == 16'd0) begin
               state_d.phase = end_phase;
            end
         end
         fcgi_pkg::PH_PAD: begin
            state_d.padding_left = padding_dec;
            if (padding_dec == 8'd0) begin
               state_d.phase = fcgi_pkg::PH_VER;
            end
         end
         default: begin
            // version byte; stray phase codes land here too
            if (in_byte != fcgi_pkg::FCGI_VERSION) begin
               result.status = fcgi_pkg::ST_BAD_VERSION;
               state_d.phase = fcgi_pkg::PH_VER;
            end else begin
               state_d.phase = fcgi_pkg::PH_TYPE;
            end
         end
      endcase

      // every params byte counts against the record content
      if (params) begin
         state_d.content_left = content_dec;
         if (content_dec == 16'd0) begin
            state_d.phase = end_phase;
         end
      end

      result.rec_id = state_d.current_id;
   end

endmodule

// ===== hdl/fcgi_rsp_reg.sv =====
// Result register with valid/ready hold for the response channel.
module fcgi_rsp_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  fcgi_pkg::result_type result_in,
   input  logic                 rsp_ready,
   output logic                 room,
   output logic                 rsp_valid,
   output fcgi_pkg::result_type result_out
);

   logic                 valid_ff;
   logic                 valid_in;
   fcgi_pkg::result_type data_ff;

   // free when empty or when the held beat leaves this cycle
   assign room     = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result_in;
      end
   end

   assign rsp_valid  = valid_ff;
   assign result_out = data_ff;

endmodule
